### sv/ole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg: shared types and constants of the ordered list engine
// Sizes of the list and the request/result fields, request codes and the
// command word broadcast to every list cell.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam int TYPE_W     = 2;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 4;
    localparam int COUNT_W    = 5;

    typedef enum logic [TYPE_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_REMOVE = 2'd2
    } t_req_type;

    // Command seen by every cell in the cycle a request is accepted
    typedef struct packed {
        logic                    ins;   // shift back, head takes the value
        logic                    rem;   // close the gap at the first match
        logic signed [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

### sv/ole_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_req_if: request channel of the ordered list engine
// Valid/ready handshake carrying the request kind and its value.
// ----------------------------------------------------------------------------
interface ole_req_if;
    logic                              valid;
    logic                              ready;
    logic [ole_pkg::TYPE_W-1:0]        req_type;
    logic signed [ole_pkg::VAL_W-1:0]  value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

### sv/ole_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_res_if: result channel of the ordered list engine
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface ole_res_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [ole_pkg::POS_W-1:0]   position;
    logic [ole_pkg::COUNT_W-1:0] entry_count;
    logic                        empty_res;
    logic                        overflow;

    modport source (output valid, output found, output position, output entry_count,
                    output empty_res, output overflow, input ready);
    modport sink   (input valid, input found, input position, input entry_count,
                    input empty_res, input overflow, output ready);
endinterface

### sv/ole_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_cell: one list entry
// Holds a word, compares it with the request value and takes the word of
// either neighbor when the list shifts.
// ----------------------------------------------------------------------------
module ole_cell (
    input  logic                             i_clk,
    input  ole_pkg::t_cell_cmd               i_cmd,
    input  logic                             i_active,     // entry below the count
    input  logic                             i_hit_in,     // match in an earlier cell
    input  logic signed [ole_pkg::VAL_W-1:0] i_prev_entry, // toward the head
    input  logic signed [ole_pkg::VAL_W-1:0] i_next_entry, // toward the tail
    output logic signed [ole_pkg::VAL_W-1:0] o_entry,
    output logic                             o_match,
    output logic                             o_hit_out
);
    import ole_pkg::*;

    logic signed [VAL_W-1:0] r_entry;
    logic signed [VAL_W-1:0] n_entry;

    assign o_match   = i_active && (r_entry == i_cmd.value);
    assign o_hit_out = i_hit_in || o_match;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            n_entry = i_prev_entry;
        end else if (i_cmd.rem && o_hit_out) begin
            // at or past the first match: pull the tail forward
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### sv/ordered_list_engine.sv
`timescale 1ns / 1ps
// The result is registered: it is valid on o_res in the cycle after the request is accepted.
// Throughput: one request per cycle; the request is taken while the result
//   register is empty or being drained in the same cycle.
// The row of list cells compares and shifts in the acceptance cycle itself.
// Reset: clears the entry count and the result valid; cell words are not
//   cleared and are only read below the count.
// ----------------------------------------------------------------------------
// ordered_list_engine: bounded list with insert, search and remove
// A row of LIST_DEPTH cells holds the list from the head. Every cell compares
// its word with the request value; a hit chain runs from the head to the tail
// so each cell knows whether the first match lies at or before it. Insert
// shifts every cell back by one and loads the head unless the list is full; remove makes every cell
// at or after the first match take its tail-side neighbor's word.
// ----------------------------------------------------------------------------
module ordered_list_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ole_req_if.sink       i_req,
    ole_res_if.source     o_res
);
    import ole_pkg::*;

    // ---- list state --------------------------------------------------------
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;

    // ---- result register ---------------------------------------------------
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic                    r_found;
    logic                    n_found;
    logic [POS_W-1:0]        r_position;
    logic [POS_W-1:0]        n_position;
    logic                    r_overflow;
    logic                    n_overflow;

    // ---- cell row wiring ---------------------------------------------------
    t_cell_cmd               cell_cmd;
    logic [LIST_DEPTH-1:0]   active;
    logic [LIST_DEPTH-1:0]   match;
    logic [LIST_DEPTH-1:0]   hit_in;
    logic [LIST_DEPTH-1:0]   hit_out;
    logic [LIST_DEPTH-1:0]   first;
    logic signed [VAL_W-1:0] entry   [LIST_DEPTH];
    logic signed [VAL_W-1:0] prev_in [LIST_DEPTH];
    logic signed [VAL_W-1:0] next_in [LIST_DEPTH];

    logic                    accept;
    logic                    full;
    logic                    any_hit;
    logic                    is_insert;
    logic                    is_search;
    logic                    is_remove;
    logic [IDX_W-1:0]        first_idx;

    // Take a request whenever the result slot is free or drains now
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign full        = (r_count == CNT_W'(LIST_DEPTH));
    assign any_hit     = hit_out[LIST_DEPTH-1];

    // Decode the request kind; the unused code does nothing
    always_comb begin
        is_insert = 1'b0;
        is_search = 1'b0;
        is_remove = 1'b0;
        unique case (i_req.req_type)
            REQ_INSERT: begin
                is_insert = 1'b1;
            end
            REQ_SEARCH: begin
                is_search = 1'b1;
            end
            REQ_REMOVE: begin
                is_remove = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Broadcast command: shifts only on an accepted request
    assign cell_cmd.ins   = accept && is_insert && !full;
    assign cell_cmd.rem   = accept && is_remove;
    assign cell_cmd.value = i_req.value;

    // ---- row of cells ------------------------------------------------------
    genvar k;
    generate
        for (k = 0; k < LIST_DEPTH; k++) begin : g_cell
            assign active[k] = (CNT_W'(k) < r_count);

            // Head cell loads the request value; the rest take the head-side word
            if (k == 0) begin : g_head
                assign prev_in[k] = i_req.value;
                assign hit_in[k]  = 1'b0;
            end else begin : g_body
                assign prev_in[k] = entry[k-1];
                assign hit_in[k]  = hit_out[k-1];
            end

            // Tail cell never holds a live word after a remove, so feed back its own
            if (k == LIST_DEPTH - 1) begin : g_tail
                assign next_in[k] = entry[k];
            end else begin : g_inner
                assign next_in[k] = entry[k+1];
            end

            assign first[k] = match[k] && !hit_in[k];

            ole_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cell_cmd),
                .i_active     (active[k]),
                .i_hit_in     (hit_in[k]),
                .i_prev_entry (prev_in[k]),
                .i_next_entry (next_in[k]),
                .o_entry      (entry[k]),
                .o_match      (match[k]),
                .o_hit_out    (hit_out[k])
            );
        end
    endgenerate

    // Encode the one-hot first match into an index
    always_comb begin
        first_idx = '0;
        for (int j = 0; j < LIST_DEPTH; j++) begin
            if (first[j]) begin
                first_idx = first_idx | IDX_W'(j);
            end
        end
    end

    // ---- count and result --------------------------------------------------
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_position  = r_position;
        n_overflow  = r_overflow;

        // Drop the held result once it is taken
        if (o_res.valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        if (accept) begin
            n_out_valid = 1'b1;
            n_found     = 1'b0;
            n_position  = '0;
            n_overflow  = 1'b0;
            if (is_insert) begin
                if (full) begin
                    n_overflow = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end else if (is_search || is_remove) begin
                if (any_hit) begin
                    n_found    = 1'b1;
                    n_position = POS_W'(first_idx);
                    if (is_remove) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_found    <= n_found;
        r_position <= n_position;
        r_overflow <= n_overflow;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.found       = r_found;
    assign o_res.position    = r_position;
    assign o_res.entry_count = COUNT_W'(r_count);
    assign o_res.empty_res   = (r_count == '0);
    assign o_res.overflow    = r_overflow;

    // ---- assertions --------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(first))
        else $error("more than one first match in the cell row");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_insert && !full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_remove && any_hit) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove with match did not shrink the list");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.found && o_res.overflow))
        else $error("result reports both a match and an overflow");

endmodule

### bench/tb_ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine: self-checking bench for the ordered list engine
// Drives insert, search, remove and unused requests through the request
// channel and keeps its own copy of the list to predict each result. Every
// accepted result is compared field by field with the oldest prediction.
// Both channels idle in random bursts, the receiver holds off once for a
// long stretch, and the last part runs back to back.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;
    import ole_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] entry_count;
        logic               empty_res;
        logic               overflow;
    } t_list_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ole_req_if req_if ();
    ole_res_if res_if ();

    ordered_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shadow list: words from the head, and how many are held
    logic signed [VAL_W-1:0] shadow_words [LIST_DEPTH];
    int unsigned             shadow_count = 0;

    t_list_result expected_results [$];

    int  error_count   = 0;
    int  cycle_count   = 0;
    bit  sender_idle   = 1'b1;
    bit  receiver_idle = 1'b1;
    bit  hold_off_req  = 1'b0;

    // Values most requests draw from, so searches and removes find matches
    logic signed [VAL_W-1:0] value_pool [8];

    // ------------------------------------------------------------------------
    // Predictor: apply one accepted request to the shadow list, queue result
    // ------------------------------------------------------------------------
    task automatic predict_list_request(input logic [TYPE_W-1:0] kind,
                                        input logic signed [VAL_W-1:0] v);
        t_list_result res;
        int unsigned  k;
        int unsigned  hit_at;
        bit           hit;
        res    = '0;
        hit    = 1'b0;
        hit_at = 0;
        if (kind == REQ_SEARCH || kind == REQ_REMOVE) begin
            for (k = 0; k < shadow_count; k++) begin
                if (!hit && shadow_words[k] == v) begin
                    hit    = 1'b1;
                    hit_at = k;
                end
            end
        end
        case (kind)
            REQ_INSERT: begin
                if (shadow_count >= LIST_DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    for (k = shadow_count; k > 0; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[0] = v;
                    shadow_count++;
                end
            end
            REQ_SEARCH: begin
                res.found    = hit;
                res.position = hit_at[POS_W-1:0];
            end
            REQ_REMOVE: begin
                res.found    = hit;
                res.position = hit_at[POS_W-1:0];
                if (hit) begin
                    for (k = hit_at; k + 1 < shadow_count; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_count--;
                end
            end
            default: begin
                // unused code: list untouched
            end
        endcase
        res.entry_count = shadow_count[COUNT_W-1:0];
        res.empty_res   = (shadow_count == 0);
        expected_results.push_back(res);
    endtask

    // Four-state compare, so an unknown result bit counts as a mismatch
    function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                          input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: check results and predict requests, both sampled at the edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_list_result want;
        if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request pending", $time);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("found", 32'(want.found), 32'(res_if.found));
                compare_field("position", 32'(want.position), 32'(res_if.position));
                compare_field("entry_count", 32'(want.entry_count),
                              32'(res_if.entry_count));
                compare_field("empty_res", 32'(want.empty_res), 32'(res_if.empty_res));
                compare_field("overflow", 32'(want.overflow), 32'(res_if.overflow));
            end
        end
        if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
            predict_list_request(req_if.req_type, req_if.value);
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready bursts, plus one long hold-off on demand
    // ------------------------------------------------------------------------
    initial begin
        int n;
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_if.ready <= 1'b0;
                for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge i_clk);
            end else if (receiver_idle && $urandom_range(3) == 0) begin
                gap = $urandom_range(12, 1);
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: offer one request, hold it until taken, maybe idle afterwards
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [TYPE_W-1:0] kind,
                                input logic signed [VAL_W-1:0] v);
        int gap;
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.value    <= v;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        if (sender_idle && $urandom_range(3) == 0) begin
            gap = $urandom_range(12, 1);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(99) < 75)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Refresh the pool; keep the extremes and zero/minus one in it
    function automatic void refresh_pool();
        int k;
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        for (k = 4; k < 8; k++)
            value_pool[k] = $urandom;
    endfunction

    // Random traffic with given insert and remove shares in percent
    task automatic send_random_requests(input int num, input int insert_pct,
                                        input int remove_pct);
        int i;
        int r;
        logic [TYPE_W-1:0] kind;
        for (i = 0; i < num; i++) begin
            r = $urandom_range(99);
            if (r < insert_pct)
                kind = REQ_INSERT;
            else if (r < insert_pct + remove_pct)
                kind = REQ_REMOVE;
            else if (r < 96)
                kind = REQ_SEARCH;
            else
                kind = REQ_UNUSED;
            send_request(kind, pick_value());
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty list, extremes, duplicates, first match, gap closing, unused code
    task automatic test_basic_operations();
        send_request(REQ_SEARCH, 32'sd5);        // search on empty list
        send_request(REQ_REMOVE, 32'sd5);        // remove on empty list
        send_request(REQ_UNUSED, 32'sd7);        // unused code, empty list
        send_request(REQ_INSERT, VAL_MIN);
        send_request(REQ_INSERT, VAL_MAX);
        send_request(REQ_INSERT, 32'sd0);
        send_request(REQ_INSERT, -32'sd1);
        send_request(REQ_INSERT, VAL_MAX);       // duplicate at the head
        send_request(REQ_SEARCH, VAL_MAX);       // first match wins
        send_request(REQ_SEARCH, VAL_MIN);       // tail match
        send_request(REQ_SEARCH, 32'sh7fff_fffe); // near miss on one bit
        send_request(REQ_REMOVE, VAL_MAX);       // remove head
        send_request(REQ_SEARCH, VAL_MAX);       // older duplicate remains
        send_request(REQ_REMOVE, 32'sd0);        // remove from the middle
        send_request(REQ_UNUSED, VAL_MIN);       // unused code, list held
        send_request(REQ_REMOVE, 32'sd12345);    // remove without match
        send_request(REQ_REMOVE, VAL_MIN);       // remove tail
        send_request(REQ_REMOVE, -32'sd1);
        send_request(REQ_REMOVE, VAL_MAX);       // list empty again
    endtask

    // Fill to the top, overflow twice, hit the last slot, then drain
    task automatic test_full_list();
        int k;
        for (k = 0; k < LIST_DEPTH; k++)
            send_request(REQ_INSERT, 32'sd100 + k);
        send_request(REQ_INSERT, VAL_MAX);       // dropped, overflow
        send_request(REQ_INSERT, VAL_MIN);       // dropped, overflow
        send_request(REQ_SEARCH, 32'sd100);      // deepest slot
        send_request(REQ_SEARCH, VAL_MAX);       // dropped value absent
        send_request(REQ_REMOVE, 32'sd100);      // remove last slot
        send_request(REQ_INSERT, VAL_MAX);       // room again
        for (k = 0; k < LIST_DEPTH; k++)
            send_request(REQ_REMOVE, $urandom_range(1) ? (32'sd100 + k) : VAL_MAX);
        send_random_requests(LIST_DEPTH, 0, 100); // remove-only traffic from the pool
    endtask

    task automatic test_random_traffic();
        refresh_pool();
        send_random_requests(400, 45, 30);
    endtask

    // Sweep the count: insert-heavy up to full, remove-heavy back down
    task automatic test_fill_and_drain();
        refresh_pool();
        send_random_requests(200, 70, 15);
        send_random_requests(200, 15, 60);
    endtask

    // Hold off the receiver while the sender keeps offering requests
    task automatic test_backpressure();
        sender_idle  = 1'b0;
        hold_off_req = 1'b1;
        refresh_pool();
        send_random_requests(100, 45, 30);
        sender_idle  = 1'b1;
    endtask

    // Last part: no idling on either side
    task automatic test_back_to_back();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        refresh_pool();
        send_random_requests(400, 50, 30);
    endtask

    task automatic finish_run();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    endtask

    initial begin
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_INSERT;
        req_if.value    = '0;
        res_if.ready    = 1'b0;
        refresh_pool();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_operations();
        test_full_list();
        test_random_traffic();
        test_fill_and_drain();
        test_backpressure();
        test_back_to_back();
        finish_run();
    end

endmodule
